>>> src/dpfm_pkg.sv
// Shared constants, codes and types for the demand paging frame manager.
package dpfm_pkg;

    localparam int PROCS          = 16;
    localparam int PROC_W         = $clog2(PROCS);
    localparam int PAGES_PER_PROC = 2048;
    localparam int PAGE_W         = $clog2(PAGES_PER_PROC);
    localparam int FRAMES         = 16384;
    localparam int FRAME_W        = $clog2(FRAMES);
    localparam int FCNT_W         = FRAME_W + 1;
    localparam int RESERVED_PAGES = 10;
    localparam int NEED_W         = 4;
    localparam int PAGE_SHIFT     = 10;
    localparam int PM_DEPTH       = PROCS * PAGES_PER_PROC;
    localparam int PM_AW          = PROC_W + PAGE_W;
    localparam int PM_W           = FRAME_W + 1;

    localparam logic [1:0] MODE_ACCESS  = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_ADMIT   = 2'd2;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_LOADED   = 3'd1;
    localparam logic [2:0] ST_SWAPPED  = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_ADMITTED = 3'd4;
    localparam logic [2:0] ST_REFUSED  = 3'd5;

    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_ACC_RD  = 16'h0004,
        S_ACC_EV  = 16'h0008,
        S_POP     = 16'h0010,
        S_FR_RD   = 16'h0020,
        S_FR_CHK  = 16'h0040,
        S_FR_END  = 16'h0080,
        S_ADM_RD  = 16'h0100,
        S_ADM_CNT = 16'h0200,
        S_ADM_DEC = 16'h0400,
        S_ADM_RD2 = 16'h0800,
        S_ADM_CHK = 16'h1000,
        S_ADM_POP = 16'h2000,
        S_OUT     = 16'h4000
    } t_state;

endpackage

>>> src/dpfm_ram.sv
// Generic simple dual-port RAM with registered read.
module dpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/demand_paging_frame_manager.sv
// Top level: page tables, free frame FIFO and the sequencer that walks them.
// After reset the block clears all 32768 page-table entries before it
// accepts an item. A hit makes one page-table read. A fault that loads a
// frame makes one page-table read plus one write. An admit makes two
// passes over the ten reserved pages; a refused admit ends after the
// first pass. Release and swap-out walk all 2048 pages of the process,
// one page after another through the single page-table read port. Each
// result is held until it is transferred, and the next item is taken
// after that.
module demand_paging_frame_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_process_id,
    input  logic [20:0] i_element_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [13:0] o_frame_number,
    output logic [4:0]  o_active_processes,
    output logic [7:0]  o_min_active,
    output logic [31:0] o_access_total,
    output logic [31:0] o_fault_total,
    output logic [31:0] o_swap_total
);
    localparam int PW = dpfm_pkg::PAGE_W;
    localparam int FW = dpfm_pkg::FRAME_W;
    localparam int CW = dpfm_pkg::FCNT_W;

    dpfm_pkg::t_state r_state, n_state;

    logic [dpfm_pkg::PM_AW-1:0]  r_clr, n_clr;
    logic [dpfm_pkg::PROC_W-1:0] r_proc, n_proc;
    logic [PW-1:0]               r_idx, n_idx;
    logic                        r_swap, n_swap;
    logic [dpfm_pkg::NEED_W-1:0] r_need, n_need;
    logic [FW-1:0]               r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]               r_count, n_count, r_fill, n_fill;
    logic [4:0]                  r_active, n_active;
    logic [7:0]                  r_min, n_min;
    logic [31:0]                 r_acc, n_acc, r_flt, n_flt, r_swp, n_swp;
    logic [dpfm_pkg::PROCS-1:0]  r_adm, n_adm;
    logic [2:0]                  r_status, n_status;
    logic [FW-1:0]               r_frame, n_frame;

    logic                        pm_we;
    logic [dpfm_pkg::PM_AW-1:0]  pm_waddr;
    logic [dpfm_pkg::PM_W-1:0]   pm_wdata, pm_q;
    logic                        ff_we;
    logic [FW-1:0]               ff_q, pop_frame;
    logic                        pm_valid;
    logic [PW:0]                 page_sum;
    logic [PW-1:0]               page;
    logic [4:0]                  act_drop;
    logic                        last_res;

    dpfm_ram #(.WIDTH(dpfm_pkg::PM_W), .DEPTH(dpfm_pkg::PM_DEPTH)) u_page_map (
        .i_clk  (i_clk),
        .i_we   (pm_we),
        .i_waddr(pm_waddr),
        .i_wdata(pm_wdata),
        .i_raddr({r_proc, r_idx}),
        .o_rdata(pm_q)
    );

    // Entries not yet written since reset are not read; pop_frame uses the head index instead.
    dpfm_ram #(.WIDTH(FW), .DEPTH(dpfm_pkg::FRAMES)) u_free_fifo (
        .i_clk  (i_clk),
        .i_we   (ff_we),
        .i_waddr(r_tail),
        .i_wdata(pm_q[FW-1:0]),
        .i_raddr(r_head),
        .o_rdata(ff_q)
    );

    assign pm_valid  = pm_q[dpfm_pkg::PM_W-1];
    assign pop_frame = ({1'b0, r_head} < r_fill) ? ff_q : r_head;
    assign page_sum  = (PW+1)'(i_element_index >> dpfm_pkg::PAGE_SHIFT)
                     + (PW+1)'(dpfm_pkg::RESERVED_PAGES);
    assign page      = (page_sum >= (PW+1)'(dpfm_pkg::PAGES_PER_PROC))
                     ? PW'(dpfm_pkg::PAGES_PER_PROC - 1) : page_sum[PW-1:0];
    assign act_drop  = (r_adm[r_proc] && r_active != 5'd0) ? r_active - 5'd1 : r_active;
    assign last_res  = (r_idx == PW'(dpfm_pkg::RESERVED_PAGES - 1));

    assign o_ready            = (r_state == dpfm_pkg::S_IDLE);
    assign o_valid            = (r_state == dpfm_pkg::S_OUT);
    assign o_status           = r_status;
    assign o_frame_number     = r_frame;
    assign o_active_processes = r_active;
    assign o_min_active       = r_min;
    assign o_access_total     = r_acc;
    assign o_fault_total      = r_flt;
    assign o_swap_total       = r_swp;

    always_comb begin
        pm_we    = 1'b0;
        pm_waddr = {r_proc, r_idx};
        pm_wdata = '0;
        ff_we    = 1'b0;
        case (r_state)
            dpfm_pkg::S_CLEAR: begin
                pm_we    = 1'b1;
                pm_waddr = r_clr;
            end
            dpfm_pkg::S_FR_CHK: begin
                pm_we = pm_valid;
                ff_we = pm_valid && (r_count < CW'(dpfm_pkg::FRAMES));
            end
            dpfm_pkg::S_POP, dpfm_pkg::S_ADM_POP: begin
                pm_we    = 1'b1;
                pm_wdata = {1'b1, pop_frame};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_proc   = r_proc;
        n_idx    = r_idx;
        n_swap   = r_swap;
        n_need   = r_need;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_fill   = r_fill;
        n_active = r_active;
        n_min    = r_min;
        n_acc    = r_acc;
        n_flt    = r_flt;
        n_swp    = r_swp;
        n_adm    = r_adm;
        n_status = r_status;
        n_frame  = r_frame;
        case (r_state)
            dpfm_pkg::S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = dpfm_pkg::S_IDLE;
                end
            end
            dpfm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_proc  = i_process_id;
                    n_frame = '0;
                    n_need  = '0;
                    n_idx   = '0;
                    case (i_mode)
                        dpfm_pkg::MODE_ACCESS: begin
                            n_idx   = page;
                            n_acc   = (r_acc == '1) ? r_acc : r_acc + 32'd1;
                            n_state = dpfm_pkg::S_ACC_RD;
                        end
                        dpfm_pkg::MODE_RELEASE: begin
                            n_swap  = 1'b0;
                            n_state = dpfm_pkg::S_FR_RD;
                        end
                        dpfm_pkg::MODE_ADMIT: begin
                            n_state = dpfm_pkg::S_ADM_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dpfm_pkg::S_ACC_RD: n_state = dpfm_pkg::S_ACC_EV;
            dpfm_pkg::S_ACC_EV: begin
                if (pm_valid) begin
                    n_status = dpfm_pkg::ST_HIT;
                    n_frame  = pm_q[FW-1:0];
                    n_state  = dpfm_pkg::S_OUT;
                end else begin
                    n_flt = (r_flt == '1) ? r_flt : r_flt + 32'd1;
                    if (r_count != '0) begin
                        n_state = dpfm_pkg::S_POP;
                    end else begin
                        n_swap  = 1'b1;
                        n_idx   = '0;
                        n_state = dpfm_pkg::S_FR_RD;
                    end
                end
            end
            dpfm_pkg::S_POP: begin
                n_head   = r_head + 1'b1;
                n_count  = r_count - 1'b1;
                n_frame  = pop_frame;
                n_status = dpfm_pkg::ST_LOADED;
                n_state  = dpfm_pkg::S_OUT;
            end
            dpfm_pkg::S_FR_RD: n_state = dpfm_pkg::S_FR_CHK;
            dpfm_pkg::S_FR_CHK: begin
                if (pm_valid && r_count < CW'(dpfm_pkg::FRAMES)) begin
                    n_tail  = r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_fill < CW'(dpfm_pkg::FRAMES)) begin
                        n_fill = r_fill + 1'b1;
                    end
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == '1) begin
                    n_state = dpfm_pkg::S_FR_END;
                end else begin
                    n_state = dpfm_pkg::S_FR_RD;
                end
            end
            dpfm_pkg::S_FR_END: begin
                n_active      = act_drop;
                n_adm[r_proc] = 1'b0;
                if (r_swap) begin
                    n_swp    = (r_swp == '1) ? r_swp : r_swp + 32'd1;
                    n_min    = ({3'b0, act_drop} < r_min) ? {3'b0, act_drop} : r_min;
                    n_status = dpfm_pkg::ST_SWAPPED;
                end else begin
                    n_status = dpfm_pkg::ST_RELEASED;
                end
                n_state = dpfm_pkg::S_OUT;
            end
            dpfm_pkg::S_ADM_RD: n_state = dpfm_pkg::S_ADM_CNT;
            dpfm_pkg::S_ADM_CNT: begin
                if (!pm_valid) begin
                    n_need = r_need + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                n_state = last_res ? dpfm_pkg::S_ADM_DEC : dpfm_pkg::S_ADM_RD;
            end
            dpfm_pkg::S_ADM_DEC: begin
                n_idx = '0;
                if (r_count < CW'(r_need)) begin
                    n_status = dpfm_pkg::ST_REFUSED;
                    n_state  = dpfm_pkg::S_OUT;
                end else begin
                    n_state = dpfm_pkg::S_ADM_RD2;
                end
            end
            dpfm_pkg::S_ADM_RD2: n_state = dpfm_pkg::S_ADM_CHK;
            dpfm_pkg::S_ADM_CHK, dpfm_pkg::S_ADM_POP: begin
                if (r_state == dpfm_pkg::S_ADM_CHK && !pm_valid) begin
                    n_state = dpfm_pkg::S_ADM_POP;
                end else begin
                    if (r_state == dpfm_pkg::S_ADM_POP) begin
                        n_head  = r_head + 1'b1;
                        n_count = r_count - 1'b1;
                    end
                    n_idx = r_idx + 1'b1;
                    if (last_res) begin
                        if (!r_adm[r_proc]) begin
                            n_adm[r_proc] = 1'b1;
                            n_active      = r_active + 5'd1;
                        end
                        n_status = dpfm_pkg::ST_ADMITTED;
                        n_state  = dpfm_pkg::S_OUT;
                    end else begin
                        n_state = dpfm_pkg::S_ADM_RD2;
                    end
                end
            end
            dpfm_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = dpfm_pkg::S_IDLE;
                end
            end
            default: n_state = dpfm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dpfm_pkg::S_CLEAR;
            r_clr    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= CW'(dpfm_pkg::FRAMES);
            r_fill   <= '0;
            r_active <= '0;
            r_min    <= 8'd255;
            r_acc    <= '0;
            r_flt    <= '0;
            r_swp    <= '0;
            r_adm    <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_fill   <= n_fill;
            r_active <= n_active;
            r_min    <= n_min;
            r_acc    <= n_acc;
            r_flt    <= n_flt;
            r_swp    <= n_swp;
            r_adm    <= n_adm;
        end
        r_proc   <= n_proc;
        r_idx    <= n_idx;
        r_swap   <= n_swap;
        r_need   <= n_need;
        r_status <= n_status;
        r_frame  <= n_frame;
    end
endmodule

>>> dv/demand_paging_frame_manager_test.sv
// Self-checking testbench for the demand paging frame manager.
module demand_paging_frame_manager_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 30_000_000;
    localparam int  DRAIN_CYCLES = 5000;
    localparam bit [31:0] SAT = 32'hFFFF_FFFF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [20:0] IDX_MAX = 21'h1FFFFF;

    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  pid;
        logic [20:0] idx;
    } t_page_req;

    typedef struct {
        logic [2:0]  status;
        logic [13:0] frame;
        logic [4:0]  active;
        logic [7:0]  min_act;
        logic [31:0] acc;
        logic [31:0] flt;
        logic [31:0] swp;
    } t_page_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_mode;
    logic [3:0]  i_process_id;
    logic [20:0] i_element_index;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [13:0] o_frame_number;
    logic [4:0]  o_active_processes;
    logic [7:0]  o_min_active;
    logic [31:0] o_access_total;
    logic [31:0] o_fault_total;
    logic [31:0] o_swap_total;

    demand_paging_frame_manager dut (.*);

    // Shadow copy of the block's state.
    logic [15:0] sh_map [dpfm_pkg::PM_DEPTH];
    logic [13:0] sh_fifo [dpfm_pkg::FRAMES];
    int          sh_head, sh_tail, sh_count, sh_active, sh_min;
    bit   [31:0] sh_acc, sh_flt, sh_swp;
    bit          sh_admitted [dpfm_pkg::PROCS];

    t_page_req  req_q [$];
    t_page_rsp  rsp_q [$];
    int         send_idle, recv_idle;
    int         errors, cycles;
    int         status_seen [6];

    function automatic bit [31:0] sat_inc(bit [31:0] v);
        return (v == SAT) ? v : v + 1;
    endfunction

    function automatic logic [13:0] take_frame();
        logic [13:0] f;
        f = sh_fifo[sh_head];
        sh_head = (sh_head + 1) % dpfm_pkg::FRAMES;
        sh_count--;
        return f;
    endfunction

    function automatic void free_process(int p);
        int a;
        for (int i = 0; i < dpfm_pkg::PAGES_PER_PROC; i++) begin
            a = p * dpfm_pkg::PAGES_PER_PROC + i;
            if (sh_map[a][15]) begin
                if (sh_count < dpfm_pkg::FRAMES) begin
                    sh_fifo[sh_tail] = sh_map[a][13:0];
                    sh_tail = (sh_tail + 1) % dpfm_pkg::FRAMES;
                    sh_count++;
                end
                sh_map[a] = '0;
            end
        end
    endfunction

    function automatic void deactivate(int p);
        if (sh_admitted[p]) begin
            sh_admitted[p] = 0;
            if (sh_active > 0) sh_active--;
        end
    endfunction

    // Applies one transfer to the shadow state, queuing a result if mode is used.
    function automatic void apply_page_request(t_page_req r);
        int        p, base, page, need;
        t_page_rsp e;
        p = r.pid % dpfm_pkg::PROCS;
        base = p * dpfm_pkg::PAGES_PER_PROC;
        e.frame = '0;
        if (r.mode == MODE_UNUSED) return;
        if (r.mode == dpfm_pkg::MODE_ACCESS) begin
            page = (r.idx >> dpfm_pkg::PAGE_SHIFT) + dpfm_pkg::RESERVED_PAGES;
            if (page >= dpfm_pkg::PAGES_PER_PROC) page = dpfm_pkg::PAGES_PER_PROC - 1;
            sh_acc = sat_inc(sh_acc);
            if (sh_map[base + page][15]) begin
                e.status = dpfm_pkg::ST_HIT;
                e.frame = sh_map[base + page][13:0];
            end else begin
                sh_flt = sat_inc(sh_flt);
                if (sh_count > 0) begin
                    e.frame = take_frame();
                    sh_map[base + page] = {2'b10, e.frame};
                    e.status = dpfm_pkg::ST_LOADED;
                end else begin
                    free_process(p);
                    sh_swp = sat_inc(sh_swp);
                    deactivate(p);
                    if (sh_active < sh_min) sh_min = sh_active;
                    e.status = dpfm_pkg::ST_SWAPPED;
                end
            end
        end else if (r.mode == dpfm_pkg::MODE_RELEASE) begin
            free_process(p);
            deactivate(p);
            e.status = dpfm_pkg::ST_RELEASED;
        end else begin
            need = 0;
            for (int i = 0; i < dpfm_pkg::RESERVED_PAGES; i++)
                if (!sh_map[base + i][15]) need++;
            if (sh_count < need) begin
                e.status = dpfm_pkg::ST_REFUSED;
            end else begin
                for (int i = 0; i < dpfm_pkg::RESERVED_PAGES; i++)
                    if (!sh_map[base + i][15]) sh_map[base + i] = {2'b10, take_frame()};
                if (!sh_admitted[p]) begin
                    sh_admitted[p] = 1;
                    sh_active++;
                end
                e.status = dpfm_pkg::ST_ADMITTED;
            end
        end
        e.active = sh_active[4:0];
        e.min_act = sh_min[7:0];
        e.acc = sh_acc;
        e.flt = sh_flt;
        e.swp = sh_swp;
        rsp_q.push_back(e);
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: one nonblocking update per signal per edge.
    always @(posedge i_clk) begin
        t_page_req r;
        if (!i_rst_n) begin
            i_valid <= 0;
            i_mode <= '0;
            i_process_id <= '0;
            i_element_index <= '0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                r.mode = i_mode;
                r.pid = i_process_id;
                r.idx = i_element_index;
                apply_page_request(r);
            end
            if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                r = req_q.pop_front();
                i_valid <= 1;
                i_mode <= r.mode;
                i_process_id <= r.pid;
                i_element_index <= r.idx;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_page_rsp e;
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (rsp_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result with no expectation: status %0d", o_status);
                end else begin
                    e = rsp_q.pop_front();
                    if (o_status <= dpfm_pkg::ST_REFUSED) status_seen[o_status]++;
                    if (o_status !== e.status || o_frame_number !== e.frame
                        || o_active_processes !== e.active || o_min_active !== e.min_act
                        || o_access_total !== e.acc || o_fault_total !== e.flt
                        || o_swap_total !== e.swp) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch exp st %0d fr %0d act %0d min %0d acc %0d flt %0d swp %0d",
                                     e.status, e.frame, e.active, e.min_act, e.acc, e.flt, e.swp);
                            $display("         got st %0d fr %0d act %0d min %0d acc %0d flt %0d swp %0d",
                                     o_status, o_frame_number, o_active_processes, o_min_active,
                                     o_access_total, o_fault_total, o_swap_total);
                        end
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("demand_paging_frame_manager_test: errors");
            $finish;
        end
    end

    function automatic void add_req(logic [1:0] m, logic [3:0] p, logic [20:0] x);
        t_page_req r;
        r.mode = m;
        r.pid = p;
        r.idx = x;
        req_q.push_back(r);
    endfunction

    // Mostly accesses with locality, some wide indexes, few slow releases.
    function automatic void add_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 84)
                add_req(dpfm_pkg::MODE_ACCESS, 4'($urandom),
                        $urandom_range(1) ? 21'($urandom) : 21'($urandom_range(8191)));
            else if (k < 88)
                add_req(dpfm_pkg::MODE_RELEASE, 4'($urandom), 21'($urandom));
            else if (k < 97)
                add_req(dpfm_pkg::MODE_ADMIT, 4'($urandom), 21'($urandom));
            else
                add_req(MODE_UNUSED, 4'($urandom), 21'($urandom));
        end
    endfunction

    task automatic run_phase(int s_idle, int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        wait (req_q.size() == 0 && !i_valid && rsp_q.size() == 0);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        for (int i = 0; i < dpfm_pkg::PM_DEPTH; i++) sh_map[i] = '0;
        for (int i = 0; i < dpfm_pkg::FRAMES; i++) sh_fifo[i] = i[13:0];
        sh_head = 0; sh_tail = 0; sh_count = dpfm_pkg::FRAMES;
        sh_active = 0; sh_min = 255;
        sh_acc = 0; sh_flt = 0; sh_swp = 0;
        for (int i = 0; i < dpfm_pkg::PROCS; i++) sh_admitted[i] = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_mode = '0;
        i_process_id = '0;
        i_element_index = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: fault then hit, index extremes, page clamp, admits, releases.
        add_req(dpfm_pkg::MODE_ACCESS, 0, 0);
        add_req(dpfm_pkg::MODE_ACCESS, 0, 1023);
        add_req(dpfm_pkg::MODE_ACCESS, 0, 1024);
        add_req(dpfm_pkg::MODE_ACCESS, 15, 21'd2086911);
        add_req(dpfm_pkg::MODE_ACCESS, 15, IDX_MAX);
        add_req(dpfm_pkg::MODE_ACCESS, 15, 21'h155555);
        add_req(dpfm_pkg::MODE_ACCESS, 15, 21'h0AAAAA);
        add_req(dpfm_pkg::MODE_ADMIT, 0, 0);
        add_req(dpfm_pkg::MODE_ADMIT, 0, IDX_MAX);
        add_req(dpfm_pkg::MODE_ADMIT, 3, 0);
        add_req(dpfm_pkg::MODE_ADMIT, 15, 0);
        add_req(dpfm_pkg::MODE_ACCESS, 3, 5000);
        add_req(dpfm_pkg::MODE_RELEASE, 3, 0);
        add_req(dpfm_pkg::MODE_RELEASE, 5, 0);
        add_req(MODE_UNUSED, 7, IDX_MAX);
        add_req(dpfm_pkg::MODE_ACCESS, 3, 5000);
        add_req(dpfm_pkg::MODE_RELEASE, 15, 0);
        add_random(320);
        run_phase(19, 62);
        add_random(330);
        run_phase(62, 19);
        add_random(340);
        run_phase(0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d hits, %0d loads, %0d swap-outs, %0d releases,",
                 status_seen[dpfm_pkg::ST_HIT], status_seen[dpfm_pkg::ST_LOADED],
                 status_seen[dpfm_pkg::ST_SWAPPED], status_seen[dpfm_pkg::ST_RELEASED]);
        $display("%0d admits, %0d refused admits; %0d failures in %0d cycles",
                 status_seen[dpfm_pkg::ST_ADMITTED], status_seen[dpfm_pkg::ST_REFUSED],
                 errors, cycles);
        if (errors == 0 && rsp_q.size() == 0) begin
            $display("demand_paging_frame_manager_test: clean");
        end else begin
            $display("demand_paging_frame_manager_test: errors");
        end
        $finish;
    end
endmodule
